// ===== rtl/hvd_pkg.sv =====
// Shared constants and types for the haversine distance unit.
// Holds the CORDIC arctangent table, the fixed-point limits and the degree-to-angle tables.
// No dependencies; every RTL file of the block imports it.
package hvd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    typedef logic [31:0]        angle_t;
    typedef logic signed [31:0] trig_t;
    typedef logic [30:0]        unit_t;
    typedef logic [60:0]        q60_t;
    typedef logic [29:0]        arc_t;
    typedef logic [6:0]         frac_t;

    localparam logic signed [29:0] LAT_LIMIT = 30'sd377487360;
    localparam logic signed [30:0] LON_LIMIT = 31'sd754974720;

    localparam logic [31:0] RECIP_45   = 32'd3054198967;
    localparam int          RECIP_SHIFT = 37;

    localparam trig_t CORDIC_GAIN_INV = 32'sd652032874;
    localparam unit_t ONE_Q30 = 31'd1073741824;
    localparam q60_t  ONE_Q60 = 61'h1000000000000000;
    localparam q60_t  HALF_Q30 = 61'd536870912;

    localparam logic [32:0] DIST_SCALE = 33'd5246834913;
    localparam logic [24:0] DIST_MAX   = 25'h1FFFFFF;
    localparam logic [24:0] DIST_HI    = 25'd20495450;

    localparam arc_t ARC_TAB [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
        30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    // Rounded r*128/45 and r*64/45 for a remainder r of a division by 45.
    localparam frac_t FRAC_FULL_TAB [0:63] = '{
        7'd0, 7'd3, 7'd6, 7'd9, 7'd11, 7'd14, 7'd17, 7'd20,
        7'd23, 7'd26, 7'd28, 7'd31, 7'd34, 7'd37, 7'd40, 7'd43,
        7'd46, 7'd48, 7'd51, 7'd54, 7'd57, 7'd60, 7'd63, 7'd65,
        7'd68, 7'd71, 7'd74, 7'd77, 7'd80, 7'd82, 7'd85, 7'd88,
        7'd91, 7'd94, 7'd97, 7'd100, 7'd102, 7'd105, 7'd108, 7'd111,
        7'd114, 7'd117, 7'd119, 7'd122, 7'd125, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    localparam frac_t FRAC_HALF_TAB [0:63] = '{
        7'd0, 7'd1, 7'd3, 7'd4, 7'd6, 7'd7, 7'd9, 7'd10,
        7'd11, 7'd13, 7'd14, 7'd16, 7'd17, 7'd18, 7'd20, 7'd21,
        7'd23, 7'd24, 7'd26, 7'd27, 7'd28, 7'd30, 7'd31, 7'd33,
        7'd34, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd43, 7'd44,
        7'd46, 7'd47, 7'd48, 7'd50, 7'd51, 7'd53, 7'd54, 7'd55,
        7'd57, 7'd58, 7'd60, 7'd61, 7'd63, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

endpackage

// ===== rtl/hvd_rot_cordic.sv =====
// Pipelined rotation CORDIC giving cosine and sine of a binary angle in Q30.
// One step per register stage plus a quadrant fold stage.
// Depends on hvd_pkg.
module hvd_rot_cordic
    import hvd_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  angle_t ang,
    output trig_t  cos_val,
    output trig_t  sin_val
);

    trig_t x_reg [0:CORDIC_STEPS];
    trig_t y_reg [0:CORDIC_STEPS];
    trig_t z_reg [0:CORDIC_STEPS];
    logic  flip_reg [0:CORDIC_STEPS];
    logic  zero_reg [0:CORDIC_STEPS];
    trig_t x_next [0:CORDIC_STEPS];
    trig_t y_next [0:CORDIC_STEPS];
    trig_t z_next [0:CORDIC_STEPS];
    logic  flip_next [0:CORDIC_STEPS];
    logic  zero_next [0:CORDIC_STEPS];

    always_comb
    begin
        flip_next[0] = ang[31] ^ ang[30];
        zero_next[0] = (ang == '0);
        z_next[0]    = signed'({ang[31] ^ flip_next[0], ang[30:0]});
        x_next[0]    = CORDIC_GAIN_INV;
        y_next[0]    = '0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam trig_t ARC = 32'(ARC_TAB[i]);
        always_comb
        begin
            flip_next[i+1] = flip_reg[i];
            zero_next[i+1] = zero_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ARC;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ARC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                flip_reg[k] <= flip_next[k];
                zero_reg[k] <= zero_next[k];
            end
        end
    end

    assign cos_val = zero_reg[CORDIC_STEPS] ? trig_t'(ONE_Q30) :
                     (flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS]);
    assign sin_val = zero_reg[CORDIC_STEPS] ? '0 :
                     (flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS]);

endmodule

// ===== rtl/haversine_distance_unit_top.sv =====
// Top level of the haversine distance unit: fixed-point pipeline from two points to distance.
// Instantiates four hvd_rot_cordic units; depends on hvd_pkg.
//
// The unit takes one pair of points per cycle while the output is not held and returns the
// distances in the order the pairs came in. The latency is set by the three iterative chains
// (sine and cosine, two square roots, arctangent), each done one step per register stage.
// All stages advance together while the output register is empty or being read; when the
// output is held, the pipeline stops, but an empty input stage still takes one more word.
module haversine_distance_unit_top
    import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_b,
    input  logic signed [30:0] lon_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [24:0]        distance
);

    localparam int NSTG = 6 + (CORDIC_STEPS + 1) + 7 + 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 2;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            en;

    logic signed [29:0] lat_a_reg, lat_b_reg;
    logic signed [30:0] lon_a_reg, lon_b_reg;
    logic signed [29:0] cla_a_reg, cla_b_reg, cla_a_next, cla_b_next;
    logic signed [30:0] clo_a_reg, clo_b_reg, clo_a_next, clo_b_next;

    logic [30:0]  nabs_reg [0:3];
    logic         nneg_reg [0:3];
    logic [30:0]  nabs_next [0:3];
    logic         nneg_next [0:3];
    logic [25:0]  q_reg [0:3];
    logic [30:0]  qabs_reg [0:3];
    logic         qneg_reg [0:3];
    logic [25:0]  rq_reg [0:3];
    logic [5:0]   r_reg [0:3];
    logic         rneg_reg [0:3];
    angle_t       ang_reg [0:3];
    angle_t       ang_next [0:3];
    trig_t        cos_w [0:3];
    trig_t        sin_w [0:3];

    unit_t ca_reg, cb_reg, sl_reg, so_reg;
    q60_t  ccp_reg, sl2_m1_reg;
    unit_t so_m1_reg;
    unit_t cc_reg, so_cc_reg;
    q60_t  sl2_cc_reg;
    q60_t  tp_reg, sl2_m2_reg;
    unit_t so_m2_reg;
    unit_t t_reg, so_t_reg;
    q60_t  sl2_t_reg;
    q60_t  tso_reg, sl2_m3_reg;
    q60_t  a_reg;
    logic [61:0] a_sum;

    logic [61:0] sqv_reg [0:SQRT_STEPS][0:1];
    logic [61:0] sqr_reg [0:SQRT_STEPS][0:1];
    logic [61:0] sqv_next [0:SQRT_STEPS][0:1];
    logic [61:0] sqr_next [0:SQRT_STEPS][0:1];

    logic signed [33:0] vx_reg [0:CORDIC_STEPS];
    logic signed [33:0] vy_reg [0:CORDIC_STEPS];
    logic signed [32:0] vz_reg [0:CORDIC_STEPS];
    logic               vzero_reg [0:CORDIC_STEPS];
    logic signed [33:0] vx_next [0:CORDIC_STEPS];
    logic signed [33:0] vy_next [0:CORDIC_STEPS];
    logic signed [32:0] vz_next [0:CORDIC_STEPS];
    logic               vzero_next [0:CORDIC_STEPS];

    unit_t       zc;
    logic [48:0] pplo_reg;
    logic [47:0] pphi_reg;
    logic [63:0] dsum;
    logic [24:0] dist_reg;

    function automatic unit_t clamp_unit(input trig_t v);
        unit_t res;
        if (v < 0)
            res = '0;
        else if (v > trig_t'(ONE_Q30))
            res = ONE_Q30;
        else
            res = unit_t'(v);
        return res;
    endfunction

    function automatic unit_t mag_unit(input trig_t v);
        trig_t m;
        m = (v < 0) ? -v : v;
        return (m > trig_t'(ONE_Q30)) ? ONE_Q30 : unit_t'(m);
    endfunction

    // Handshake and valid pipeline.
    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en || !vld_reg[0];
    assign out_valid = vld_reg[NSTG-1];
    assign distance  = dist_reg;

    always_comb
    begin
        vld_next[0] = in_ready ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = en ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            lat_a_reg <= lat_a;
            lon_a_reg <= lon_a;
            lat_b_reg <= lat_b;
            lon_b_reg <= lon_b;
        end
    end

    // Saturate the coordinates, then form magnitudes of the four angle operands.
    always_comb
    begin
        cla_a_next = (lat_a_reg > LAT_LIMIT) ? LAT_LIMIT :
                     ((lat_a_reg < -LAT_LIMIT) ? -LAT_LIMIT : lat_a_reg);
        cla_b_next = (lat_b_reg > LAT_LIMIT) ? LAT_LIMIT :
                     ((lat_b_reg < -LAT_LIMIT) ? -LAT_LIMIT : lat_b_reg);
        clo_a_next = (lon_a_reg > LON_LIMIT) ? LON_LIMIT :
                     ((lon_a_reg < -LON_LIMIT) ? -LON_LIMIT : lon_a_reg);
        clo_b_next = (lon_b_reg > LON_LIMIT) ? LON_LIMIT :
                     ((lon_b_reg < -LON_LIMIT) ? -LON_LIMIT : lon_b_reg);
    end

    logic signed [31:0] opnd [0:3];

    always_comb
    begin
        opnd[0] = 32'(cla_a_reg);
        opnd[1] = 32'(cla_b_reg);
        opnd[2] = 32'(cla_b_reg) - 32'(cla_a_reg);
        opnd[3] = 32'(clo_b_reg) - 32'(clo_a_reg);
        for (int c = 0; c < 4; c++)
        begin
            nneg_next[c] = opnd[c] < 0;
            nabs_next[c] = 31'((opnd[c] < 0) ? -opnd[c] : opnd[c]);
        end
    end

    // Degrees*2^22 to binary angle n*128/45 (n*64/45 for diffs): floor(n/45), rounded remainder.
    for (genvar c = 0; c < 4; c++)
    begin : g_ang
        logic [63:0] qprod;
        logic [32:0] mag;
        assign qprod = 64'(nabs_reg[c]) * 64'(RECIP_45);
        always_comb
        begin
            if (c < 2)
                mag = {rq_reg[c], 7'd0} + 33'(FRAC_FULL_TAB[r_reg[c]]);
            else
                mag = {1'b0, rq_reg[c], 6'd0} + 33'(FRAC_HALF_TAB[r_reg[c]]);
            ang_next[c] = rneg_reg[c] ? 32'(-mag) : mag[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nabs_reg[c] <= nabs_next[c];
                nneg_reg[c] <= nneg_next[c];
                q_reg[c]    <= qprod[RECIP_SHIFT+25:RECIP_SHIFT];
                qabs_reg[c] <= nabs_reg[c];
                qneg_reg[c] <= nneg_reg[c];
                r_reg[c]    <= 6'(qabs_reg[c] - 31'(q_reg[c]) * 31'd45);
                rq_reg[c]   <= q_reg[c];
                rneg_reg[c] <= qneg_reg[c];
                ang_reg[c]  <= ang_next[c];
            end
        end

        hvd_rot_cordic u_rot (
            .clk     (clk),
            .en      (en),
            .ang     (ang_reg[c]),
            .cos_val (cos_w[c]),
            .sin_val (sin_w[c])
        );
    end

    // Haversine term a = sin^2(dlat/2) + cos(lat_a)*cos(lat_b)*sin^2(dlon/2), Q60.
    assign a_sum = 62'(sl2_m3_reg) + 62'(tso_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cla_a_reg  <= cla_a_next;
            cla_b_reg  <= cla_b_next;
            clo_a_reg  <= clo_a_next;
            clo_b_reg  <= clo_b_next;
            ca_reg     <= clamp_unit(cos_w[0]);
            cb_reg     <= clamp_unit(cos_w[1]);
            sl_reg     <= mag_unit(sin_w[2]);
            so_reg     <= mag_unit(sin_w[3]);
            ccp_reg    <= 61'(ca_reg) * 61'(cb_reg);
            sl2_m1_reg <= 61'(sl_reg) * 61'(sl_reg);
            so_m1_reg  <= so_reg;
            cc_reg     <= 31'((ccp_reg + HALF_Q30) >> 30);
            sl2_cc_reg <= sl2_m1_reg;
            so_cc_reg  <= so_m1_reg;
            tp_reg     <= 61'(cc_reg) * 61'(so_cc_reg);
            sl2_m2_reg <= sl2_cc_reg;
            so_m2_reg  <= so_cc_reg;
            t_reg      <= 31'((tp_reg + HALF_Q30) >> 30);
            sl2_t_reg  <= sl2_m2_reg;
            so_t_reg   <= so_m2_reg;
            tso_reg    <= 61'(t_reg) * 61'(so_t_reg);
            sl2_m3_reg <= sl2_t_reg;
            a_reg      <= (a_sum > 62'(ONE_Q60)) ? ONE_Q60 : 61'(a_sum);
        end
    end

    // Two digit-by-digit square roots, floor(sqrt(a)) and floor(sqrt(1 - a)), one bit per stage.
    always_comb
    begin
        sqv_next[0][0] = 62'(a_reg);
        sqv_next[0][1] = 62'(ONE_Q60 - a_reg);
        sqr_next[0][0] = '0;
        sqr_next[0][1] = '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sq
        localparam logic [61:0] SQ_BIT = 62'(1) << (60 - 2 * k);
        for (genvar j = 0; j < 2; j++)
        begin : g_ch
            logic [61:0] trial;
            always_comb
            begin
                trial = sqr_reg[k][j] + SQ_BIT;
                if (sqv_reg[k][j] >= trial)
                begin
                    sqv_next[k+1][j] = sqv_reg[k][j] - trial;
                    sqr_next[k+1][j] = (sqr_reg[k][j] >> 1) + SQ_BIT;
                end
                else
                begin
                    sqv_next[k+1][j] = sqv_reg[k][j];
                    sqr_next[k+1][j] = sqr_reg[k][j] >> 1;
                end
            end
        end
    end

    // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)).
    always_comb
    begin
        vx_next[0]    = 34'(sqr_reg[SQRT_STEPS][1]);
        vy_next[0]    = 34'(sqr_reg[SQRT_STEPS][0]);
        vz_next[0]    = '0;
        vzero_next[0] = (sqr_reg[SQRT_STEPS][0] == '0);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        localparam logic signed [32:0] VARC = 33'(ARC_TAB[i]);
        always_comb
        begin
            vzero_next[i+1] = vzero_reg[i];
            if (vy_reg[i] > 0)
            begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + VARC;
            end
            else
            begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - VARC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    sqv_reg[k][j] <= sqv_next[k][j];
                    sqr_reg[k][j] <= sqr_next[k][j];
                end
            end
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                vx_reg[k]    <= vx_next[k];
                vy_reg[k]    <= vy_next[k];
                vz_reg[k]    <= vz_next[k];
                vzero_reg[k] <= vzero_next[k];
            end
        end
    end

    // Scale the central angle to kilometers times 2^10 in two partial products.
    always_comb
    begin
        if (vzero_reg[CORDIC_STEPS] || vz_reg[CORDIC_STEPS] < 0)
            zc = '0;
        else if (vz_reg[CORDIC_STEPS] > 33'(ONE_Q30))
            zc = ONE_Q30;
        else
            zc = 31'(vz_reg[CORDIC_STEPS]);
    end

    assign dsum = 64'(pplo_reg) + (64'(pphi_reg) << 16) + (64'(1) << 37);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pplo_reg <= 49'(zc[15:0]) * 49'(DIST_SCALE);
            pphi_reg <= 48'(zc[30:16]) * 48'(DIST_SCALE);
            dist_reg <= (dsum[63:38] > 26'(DIST_MAX)) ? DIST_MAX : dsum[62:38];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("Input stalled while the output side was free.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance <= DIST_HI))
        else $error("Distance beyond half the circumference.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("Output word dropped without being taken.");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the haversine distance unit.
// Drives point pairs through a valid/ready channel and checks each distance word against a
// fixed-point predictor written in this file; depends on hvd_pkg and the RTL top level.
module tb_top
    import hvd_pkg::*;
();

    localparam longint LAT_MAX = 377487360;
    localparam longint LON_MAX = 754974720;
    localparam longint Q30 = 64'd1 << 30;
    localparam longint Q60 = 64'd1 << 60;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 109;
    localparam int RANDOM_WORDS = 1280;

    localparam longint ARCS [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    typedef struct packed {
        logic [29:0] lat_a;
        logic [30:0] lon_a;
        logic [29:0] lat_b;
        logic [30:0] lon_b;
        logic        has_exp;
        logic [24:0] exp_dist;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [29:0] lat_a = '0;
    logic signed [30:0] lon_a = '0;
    logic signed [29:0] lat_b = '0;
    logic signed [30:0] lon_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [24:0] distance;

    logic [24:0] pending_dist [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    haversine_distance_unit_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint sat(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] deg_to_angle(longint n, longint mul);
        longint p;
        longint r;
        p = n * mul;
        if (p >= 0)
            r = (2 * p + 45) / 90;
        else
            r = -((-2 * p + 45) / 90);
        return r[31:0];
    endfunction

    task automatic rotate_angle(input logic [31:0] ang, output longint c, output longint s);
        bit flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (ang == 0)
        begin
            c = Q30;
            s = 0;
            return;
        end
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000)
        begin
            ang = ang - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < 30; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCS[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint root_floor(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint arc_of(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (y == 0)
            return 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += ARCS[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARCS[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > Q30)
            z = Q30;
        return z;
    endfunction

    function automatic longint unit_mag(longint v, bit use_abs);
        if (use_abs && v < 0)
            v = -v;
        if (v < 0)
            v = 0;
        return v > Q30 ? Q30 : v;
    endfunction

    task automatic predict_distance(input logic [29:0] la_in, input logic [30:0] oa_in,
                                    input logic [29:0] lb_in, input logic [30:0] ob_in,
                                    output logic [24:0] dist_out);
        longint la, oa, lb, ob, ca, cb, sl, so, unused;
        longint cc, tt, a, yq, xq, z;
        logic [127:0] prod;
        la = sat(longint'($signed(la_in)), LAT_MAX);
        oa = sat(longint'($signed(oa_in)), LON_MAX);
        lb = sat(longint'($signed(lb_in)), LAT_MAX);
        ob = sat(longint'($signed(ob_in)), LON_MAX);
        rotate_angle(deg_to_angle(la, 128), ca, unused);
        rotate_angle(deg_to_angle(lb, 128), cb, unused);
        rotate_angle(deg_to_angle(lb - la, 64), unused, sl);
        rotate_angle(deg_to_angle(ob - oa, 64), unused, so);
        ca = unit_mag(ca, 1'b0);
        cb = unit_mag(cb, 1'b0);
        sl = unit_mag(sl, 1'b1);
        so = unit_mag(so, 1'b1);
        cc = (ca * cb + (64'd1 << 29)) >> 30;
        tt = (cc * so + (64'd1 << 29)) >> 30;
        a = sl * sl + tt * so;
        if (a > Q60)
            a = Q60;
        yq = root_floor(a);
        xq = root_floor(Q60 - a);
        z = arc_of(xq, yq);
        prod = (128'(z) * 128'd5246834913 + (128'd1 << 37)) >> 38;
        dist_out = (prod > 128'h1FF_FFFF) ? 25'h1FF_FFFF : prod[24:0];
    endtask

    task automatic send_word(input logic [29:0] la, input logic [30:0] oa,
                             input logic [29:0] lb, input logic [30:0] ob);
        logic [24:0] d;
        predict_distance(la, oa, lb, ob, d);
        pending_dist.push_back(d);
        in_valid <= 1'b1;
        lat_a <= la;
        lon_a <= oa;
        lat_b <= lb;
        lon_b <= ob;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [29:0] rand_lat();
        case ($urandom_range(0, 9))
            0: return 30'($urandom());
            1: return $urandom_range(0, 1) ? 30'sd377487360 : -30'sd377487360;
            default: return 30'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        endcase
    endfunction

    function automatic logic [30:0] rand_lon();
        case ($urandom_range(0, 9))
            0: return 31'($urandom());
            1: return $urandom_range(0, 1) ? 31'sd754974720 : -31'sd754974720;
            default: return 31'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        endcase
    endfunction

    // Receiver stall pattern: long open stretches, then bursts of random backpressure.
    always @(posedge clk)
    begin
        int phase;
        phase = int'(($time / 2) % 600);
        if (!rst_n)
            out_ready <= 1'b0;
        else if (phase < 150)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        logic [24:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                $error("distance word with nothing expected: %0d", distance);
                errors++;
            end
            else
            begin
                want = pending_dist.pop_front();
                if (distance !== want)
                begin
                    $error("distance mismatch: expected %0d, actual %0d", want, distance);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (!stim_done || pending_dist.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    row_t rows [$];
    logic [24:0] got;

    initial
    begin
        rows = '{
            '{30'sd0, 31'sd0, 30'sd0, 31'sd0, 1'b1, 25'd0},
            '{30'sd377487360, 31'sd0, 30'sd377487360, 31'sd754974720, 1'b1, 25'd0},
            '{30'sd100000, 31'sd5000, 30'sd100000, 31'sd5000, 1'b1, 25'd0},
            '{30'sd377487360, 31'sd0, -30'sd377487360, 31'sd0, 1'b0, 25'd0},
            '{30'sd0, -31'sd754974720, 30'sd0, 31'sd754974720, 1'b0, 25'd0},
            '{30'sd0, 31'sd0, 30'sd0, 31'sd754974720, 1'b0, 25'd0},
            '{30'h1FFF_FFFF, 31'h3FFF_FFFF, 30'h2000_0000, 31'h4000_0000, 1'b0, 25'd0},
            '{30'h2000_0000, 31'h4000_0000, 30'h1FFF_FFFF, 31'h3FFF_FFFF, 1'b0, 25'd0},
            '{30'h3FFF_FFFF, 31'h7FFF_FFFF, 30'd1, 31'd1, 1'b0, 25'd0},
            '{30'sd0, -31'sd700000000, 30'sd0, 31'sd700000000, 1'b0, 25'd0},
            '{30'sd188743680, 31'sd377487360, -30'sd188743680, -31'sd377487360, 1'b0, 25'd0},
            '{30'sd1, 31'sd0, 30'sd0, 31'sd0, 1'b0, 25'd0},
            '{30'sd0, 31'sd1, 30'sd0, 31'sd0, 1'b0, 25'd0},
            '{30'sd377487359, 31'sd0, 30'sd377487360, 31'sd754974720, 1'b0, 25'd0},
            '{30'sd209715200, 31'sd1000, 30'sd209715200, 31'sd1000, 1'b1, 25'd0},
            '{-30'sd377487360, 31'sd12345, -30'sd377487360, -31'sd54321, 1'b0, 25'd0}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            if (rows[i].has_exp)
            begin
                predict_distance(rows[i].lat_a, rows[i].lon_a, rows[i].lat_b, rows[i].lon_b,
                                 got);
                if (got !== rows[i].exp_dist)
                begin
                    $error("distance mismatch: expected %0d, actual %0d (predictor)",
                           rows[i].exp_dist, got);
                    errors++;
                end
            end
            send_word(rows[i].lat_a, rows[i].lon_a, rows[i].lat_b, rows[i].lon_b);
        end
        idle_sender(1);
        while (pending_dist.size() != 0)
            @(posedge clk);
        for (int n = 0; n < RANDOM_WORDS; )
        begin
            int burst;
            logic [29:0] la;
            logic [30:0] oa;
            burst = $urandom_range(1, 60);
            for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++)
            begin
                la = rand_lat();
                oa = rand_lon();
                case ($urandom_range(0, 7))
                    0: send_word(la, oa, la, oa);
                    1: send_word(la, oa, la + 30'($urandom_range(0, 64)) - 30'd32,
                                 oa + 31'($urandom_range(0, 64)) - 31'd32);
                    default: send_word(la, oa, rand_lat(), rand_lon());
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/hvd_pkg.sv
rtl/hvd_rot_cordic.sv
rtl/haversine_distance_unit_top.sv
tb/tb_top.sv
